// File: hw/rtl/cfp_pkg.sv
// cfp_pkg: mode codes, frame constants and letter decode for the command frame parser
// no dependencies; imported by command_frame_parser
package cfp_pkg;

    // mode codes seen on the result channel
    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_O       = 4'd1;
    localparam logic [3:0] MODE_B       = 4'd2;
    localparam logic [3:0] MODE_E       = 4'd3;
    localparam logic [3:0] MODE_R       = 4'd4;
    localparam logic [3:0] MODE_P       = 4'd5;
    localparam logic [3:0] MODE_T       = 4'd6;
    localparam logic [3:0] MODE_S       = 4'd7;
    localparam logic [3:0] MODE_J       = 4'd8;
    localparam logic [3:0] MODE_Q       = 4'd9;
    localparam logic [3:0] MODE_DONE    = 4'd10;
    localparam logic [3:0] MODE_COLLECT = 4'd11;

    // frame framing and command codes
    localparam logic [7:0] START_BYTE  = 8'hEE;
    localparam logic [7:0] END_BYTE    = 8'hFF;
    localparam logic [6:0] SUM_MASK    = 7'h7F;
    localparam logic [7:0] FUNC_MOTOR  = 8'h10;
    localparam logic [7:0] INDEX_MOTOR = 8'h01;

    // frame byte positions
    localparam logic [3:0] FRAME_LEN  = 4'd7;
    localparam logic [3:0] LAST_POS   = 4'd6;
    localparam int         STORE_SIZE = 8;

    // letter commands map onto modes 1 to 9, anything else gives idle (no change)
    function automatic logic [3:0] letter_mode(input logic [7:0] b);
        logic [3:0] m;
        case (b)
            8'h4F:   m = MODE_O;
            8'h42:   m = MODE_B;
            8'h45:   m = MODE_E;
            8'h52:   m = MODE_R;
            8'h50:   m = MODE_P;
            8'h54:   m = MODE_T;
            8'h53:   m = MODE_S;
            8'h4A:   m = MODE_J;
            8'h51:   m = MODE_Q;
            default: m = MODE_IDLE;
        endcase
        return m;
    endfunction

endpackage

// File: hw/rtl/command_frame_parser.sv
// a byte accepted into the input register has its result loaded into the result register
// once the result register is free, and o_valid then rises;
// throughput: one byte per cycle, sustained under no stall.
// the decode of each byte and the fixed four-byte checksum sit in one combinational
// stage between the input register and the result register.
// reset (i_rst_n low, synchronous) clears both valid flags, the mode, the byte count and
// the held speed target; the frame byte store is not reset and is always written first.
// command_frame_parser: byte-wise mode decoder and seven-byte command frame checker
// depends on cfp_pkg
module command_frame_parser
    import cfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel in
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // result channel out
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_mode,
    output logic       o_frame_done,
    output logic       o_frame_ok,
    output logic [7:0] o_frame_index,
    output logic [7:0] o_frame_high,
    output logic [7:0] o_frame_low,
    output logic [7:0] o_frame_func,
    output logic       o_motor_strobe,
    output logic [7:0] o_motor_drive,
    output logic [7:0] o_speed_target
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    logic [3:0] r_mode, n_mode;
    logic [3:0] r_count, n_count;
    logic [7:0] r_speed, n_speed;
    logic [7:0] r_store [STORE_SIZE];

    // result register
    logic       r_out_valid;
    logic [3:0] r_out_mode;
    logic       r_out_done, n_done;
    logic       r_out_ok, n_ok;
    logic [7:0] r_out_index, r_out_high, r_out_low, r_out_func;
    logic       r_out_strobe, n_strobe;
    logic [7:0] r_out_drive;
    logic [7:0] r_out_speed;

    logic       out_free;
    logic       advance;
    logic       in_take;
    logic       store_wr;
    logic [2:0] store_addr;
    logic [3:0] count_inc;
    logic [9:0] sum;
    logic [3:0] letter;

    // handshake: the result register frees when empty or taken this edge
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    // per-byte decode and frame check
    always_comb begin
        n_mode     = r_mode;
        n_count    = r_count;
        n_speed    = r_speed;
        n_done     = 1'b0;
        n_ok       = 1'b0;
        n_strobe   = 1'b0;
        store_wr   = 1'b0;
        store_addr = r_count[2:0];
        count_inc  = r_count + 4'd1;
        letter     = letter_mode(r_in_byte);
        // bytes 1 to 4 come from the store; the checksum is over these
        sum = {2'b00, r_store[1]} + {2'b00, r_store[2]}
            + {2'b00, r_store[3]} + {2'b00, r_store[4]};
        if (r_mode == MODE_COLLECT) begin
            store_wr = 1'b1;
            n_count  = count_inc;
            if (r_in_byte == END_BYTE && count_inc == FRAME_LEN) begin
                n_mode = MODE_DONE;
                n_done = 1'b1;
            end
            if (count_inc > FRAME_LEN) begin
                n_count = 4'd0;
                n_mode  = MODE_IDLE;
            end
        end else if (r_in_byte == START_BYTE) begin
            store_wr   = 1'b1;
            store_addr = 3'd0;
            n_count    = 4'd1;
            n_mode     = MODE_COLLECT;
        end else if (letter != MODE_IDLE) begin
            n_mode = letter;
        end
        // the last frame byte is the current one, so it is taken straight from input
        if (n_done) begin
            n_ok = (r_store[0] == START_BYTE) && (r_in_byte == END_BYTE)
                && (r_store[5] == {1'b0, sum[6:0] & SUM_MASK})
                && (r_count == LAST_POS);
            if (n_ok && r_store[4] == FUNC_MOTOR && r_store[1] == INDEX_MOTOR) begin
                n_strobe = 1'b1;
                if (r_store[3] != 8'd0) begin
                    n_speed = r_store[3];
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // parser state, moves once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= 4'd0;
            r_speed <= 8'd0;
        end else if (advance) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_speed <= n_speed;
        end
    end

    // frame byte store
    always_ff @(posedge i_clk) begin
        if (advance && store_wr) begin
            r_store[store_addr] <= r_in_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_mode   <= n_mode;
            r_out_done   <= n_done;
            r_out_ok     <= n_ok;
            r_out_index  <= n_done ? r_store[1] : 8'd0;
            r_out_high   <= n_done ? r_store[2] : 8'd0;
            r_out_low    <= n_done ? r_store[3] : 8'd0;
            r_out_func   <= n_done ? r_store[4] : 8'd0;
            r_out_strobe <= n_strobe;
            r_out_drive  <= n_strobe ? r_store[2] : 8'd0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mode         = r_out_mode;
    assign o_frame_done   = r_out_done;
    assign o_frame_ok     = r_out_ok;
    assign o_frame_index  = r_out_index;
    assign o_frame_high   = r_out_high;
    assign o_frame_low    = r_out_low;
    assign o_frame_func   = r_out_func;
    assign o_motor_strobe = r_out_strobe;
    assign o_motor_drive  = r_out_drive;
    assign o_speed_target = r_out_speed;

    // held speed target travels with the result
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_speed <= n_speed;
        end
    end

    // checks
    a_done_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_mode == MODE_DONE)
        else $error("frame done without done mode");

    a_strobe_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_motor_strobe |-> o_frame_ok && o_frame_done)
        else $error("motor strobe from an unchecked frame");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FRAME_LEN)
        else $error("byte count out of range");

    a_collect_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_COLLECT |-> r_count != 4'd0)
        else $error("collecting with zero count");

    a_speed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(advance) && $past(i_rst_n) |-> $stable(r_speed))
        else $error("speed target moved without a transaction");

endmodule

// File: dv/command_frame_parser_tb.sv
// command_frame_parser_tb: self-checking bench for the byte-wise mode decoder and frame checker
// drives directed and random byte streams under random flow control; depends on cfp_pkg
`timescale 1ns / 100ps

module command_frame_parser_tb;
    import cfp_pkg::*;

    // expected contents of one result transaction
    typedef struct packed {
        logic [3:0] mode;
        logic       done;
        logic       ok;
        logic [7:0] index;
        logic [7:0] high;
        logic [7:0] low;
        logic [7:0] func;
        logic       strobe;
        logic [7:0] drive;
        logic [7:0] speed;
    } t_parse_result;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       i_stall   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_mode;
    logic       o_frame_done;
    logic       o_frame_ok;
    logic [7:0] o_frame_index;
    logic [7:0] o_frame_high;
    logic [7:0] o_frame_low;
    logic [7:0] o_frame_func;
    logic       o_motor_strobe;
    logic [7:0] o_motor_drive;
    logic [7:0] o_speed_target;

    // byte stream waiting to be sent and results waiting to be seen
    logic [7:0]    rx_stream[$];
    t_parse_result pending_results[$];
    t_parse_result seen;

    // shadow of the parser state
    logic [3:0] mode_q;
    logic [3:0] count_q;
    logic [7:0] frame_q[8];
    logic [7:0] speed_q;

    int unsigned n_bytes;
    int unsigned bytes_in;
    int unsigned results_out;
    int unsigned frames_done;
    int unsigned frames_ok;
    int unsigned motor_cmds;
    int unsigned mismatches;
    int unsigned hold_left;
    bit          hold_used;
    bit          byte_taken;

    command_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mode         (o_mode),
        .o_frame_done   (o_frame_done),
        .o_frame_ok     (o_frame_ok),
        .o_frame_index  (o_frame_index),
        .o_frame_high   (o_frame_high),
        .o_frame_low    (o_frame_low),
        .o_frame_func   (o_frame_func),
        .o_motor_strobe (o_motor_strobe),
        .o_motor_drive  (o_motor_drive),
        .o_speed_target (o_speed_target)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // letter commands onto modes, idle meaning no change
    function automatic logic [3:0] decode_letter(input logic [7:0] b);
        logic [3:0] m;
        case (b)
            "O":     m = MODE_O;
            "B":     m = MODE_B;
            "E":     m = MODE_E;
            "R":     m = MODE_R;
            "P":     m = MODE_P;
            "T":     m = MODE_T;
            "S":     m = MODE_S;
            "J":     m = MODE_J;
            "Q":     m = MODE_Q;
            default: m = MODE_IDLE;
        endcase
        return m;
    endfunction

    // advance the shadow state by one received byte and give the result it causes
    function automatic t_parse_result parse_byte(input logic [7:0] b);
        t_parse_result r;
        logic [3:0]    m;
        logic [9:0]    sum;
        r = '0;
        if (mode_q == MODE_COLLECT) begin
            frame_q[count_q[2:0]] = b;
            count_q = count_q + 4'd1;
            if (b == END_BYTE && count_q == FRAME_LEN) begin
                mode_q = MODE_DONE;
                r.done = 1'b1;
            end
            if (count_q > FRAME_LEN) begin
                count_q = 4'd0;
                mode_q = MODE_IDLE;
            end
        end else if (b == START_BYTE) begin
            frame_q[0] = START_BYTE;
            count_q = 4'd1;
            mode_q = MODE_COLLECT;
        end else begin
            m = decode_letter(b);
            if (m != MODE_IDLE)
                mode_q = m;
        end
        // checksum and motor command on a finished frame
        if (r.done) begin
            sum = frame_q[1] + frame_q[2] + frame_q[3] + frame_q[4];
            r.ok = frame_q[0] == START_BYTE && frame_q[6] == END_BYTE &&
                   frame_q[5] == {1'b0, sum[6:0] & SUM_MASK};
            r.index = frame_q[1];
            r.high = frame_q[2];
            r.low = frame_q[3];
            r.func = frame_q[4];
            if (r.ok && frame_q[4] == FUNC_MOTOR && frame_q[1] == INDEX_MOTOR) begin
                r.strobe = 1'b1;
                r.drive = frame_q[2];
                if (frame_q[3] != 8'h00)
                    speed_q = frame_q[3];
            end
        end
        r.mode = mode_q;
        r.speed = speed_q;
        return r;
    endfunction

    // queue one seven byte frame; a bad end byte is followed by an eighth byte
    task automatic add_frame(input logic [7:0] idx, input logic [7:0] hi, input logic [7:0] lo,
                             input logic [7:0] fn, input bit good_sum, input bit good_end);
        logic [9:0] sum;
        logic [7:0] tail;
        sum = idx + hi + lo + fn;
        rx_stream.push_back(START_BYTE);
        rx_stream.push_back(idx);
        rx_stream.push_back(hi);
        rx_stream.push_back(lo);
        rx_stream.push_back(fn);
        rx_stream.push_back(good_sum ? {1'b0, sum[6:0]} : 8'($urandom_range(255)));
        if (good_end) begin
            rx_stream.push_back(END_BYTE);
        end else begin
            tail = 8'($urandom_range(254));
            rx_stream.push_back(tail);
            rx_stream.push_back(8'($urandom_range(255)));
        end
    endtask

    // idle percentage per phase: receiver-heavy, then swapped to sender-heavy, then none
    function automatic int unsigned idle_pct(input bit sender);
        if (bytes_in < n_bytes / 3)
            return sender ? 33 : 51;
        else if (bytes_in < 2 * n_bytes / 3)
            return sender ? 51 : 33;
        return 0;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // byte driver: holds a stalled transaction, otherwise offers the next byte or idles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || byte_taken) begin
            byte_taken = 1'b0;
            if (rx_stream.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                i_valid <= 1'b1;
                i_rx_byte <= rx_stream.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off part way through, so the parser backs up
    always @(negedge i_clk) begin
        if (!hold_used && bytes_in >= 150) begin
            hold_left <= 60;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result stall
    always @(negedge i_clk) begin
        i_stall <= hold_left != 0 || $urandom_range(99) < idle_pct(1'b0);
    end

    // accepted byte transactions feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            pending_results.push_back(parse_byte(i_rx_byte));
            bytes_in++;
            byte_taken = 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_out++;
            if (pending_results.size() == 0) begin
                $error("result transaction with no byte outstanding");
                mismatches++;
            end else begin
                seen = pending_results.pop_front();
                if (seen.done) frames_done++;
                if (seen.ok) frames_ok++;
                if (seen.strobe) motor_cmds++;
                check_field("mode", seen.mode, o_mode);
                check_field("frame_done", seen.done, o_frame_done);
                check_field("frame_ok", seen.ok, o_frame_ok);
                check_field("frame_index", seen.index, o_frame_index);
                check_field("frame_high", seen.high, o_frame_high);
                check_field("frame_low", seen.low, o_frame_low);
                check_field("frame_func", seen.func, o_frame_func);
                check_field("motor_strobe", seen.strobe, o_motor_strobe);
                check_field("motor_drive", seen.drive, o_motor_drive);
                check_field("speed_target", seen.speed, o_speed_target);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        string      letters;
        int unsigned pick;
        letters = "OBERPTSJQ";
        mode_q = MODE_IDLE;
        count_q = 4'd0;
        speed_q = 8'h00;
        foreach (frame_q[k])
            frame_q[k] = 8'h00;

        // every letter command, then a byte that decodes to nothing
        for (int k = 0; k < 9; k++)
            rx_stream.push_back(letters[k]);
        rx_stream.push_back(8'h00);
        // good motor frame with the top bit of the sum dropped by the mask
        add_frame(INDEX_MOTOR, 8'h80, 8'h7F, FUNC_MOTOR, 1'b1, 1'b1);
        // start straight after a finished frame, letters and start byte as data,
        // end byte too early, seventh byte not the end byte so an eighth byte resets
        rx_stream.push_back(START_BYTE);
        rx_stream.push_back("O");
        rx_stream.push_back(START_BYTE);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(END_BYTE);
        rx_stream.push_back("Q");
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);

        // random part: mostly frames with random content, the rest letters and noise
        while (rx_stream.size() < 750) begin
            pick = $urandom_range(99);
            if (pick < 65)
                add_frame(($urandom_range(99) < 60) ? INDEX_MOTOR : 8'($urandom_range(255)),
                          8'($urandom_range(255)),
                          ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom_range(255)),
                          ($urandom_range(99) < 60) ? FUNC_MOTOR : 8'($urandom_range(255)),
                          $urandom_range(99) < 85, $urandom_range(99) < 90);
            else if (pick < 80)
                rx_stream.push_back(letters[$urandom_range(8)]);
            else
                rx_stream.push_back(8'($urandom_range(255)));
        end
        n_bytes = rx_stream.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_in < n_bytes)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d bytes and checked %0d results under varying flow control",
                 bytes_in, results_out);
        $display("%0d frames completed, %0d passed, %0d motor commands",
                 frames_done, frames_ok, motor_cmds);
        if (mismatches == 0)
            $display("command_frame_parser verification clean");
        else
            $display("command_frame_parser verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #200000;
        $display("command_frame_parser verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/cfp_pkg.sv
hw/rtl/command_frame_parser.sv
dv/command_frame_parser_tb.sv
